// ===== src/gfa_pkg.sv =====
// Shared types and constants of the GNSS fix averager.
package gfa_pkg;

	localparam int MaxFixesDefault = 255;
	localparam int CntW = 8;
	localparam int SumW = 40;

	localparam logic [1:0] FUNC_BEGIN  = 2'd0;
	localparam logic [1:0] FUNC_FEED   = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;
	localparam logic [1:0] FUNC_ABORT  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_WRONG    = 3'd1;
	localparam logic [2:0] ST_ABORTED  = 3'd2;
	localparam logic [2:0] ST_TOO_FEW  = 3'd3;
	localparam logic [2:0] ST_PT_LIMIT = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	localparam logic [1:0] REG_MIN_Q   = 2'd0;
	localparam logic [1:0] REG_REQ     = 2'd1;
	localparam logic [1:0] REG_MAX_PTS = 2'd2;

	localparam logic [3:0] QUAL_SEED = 4'd4;

	// request to the shared divider
	typedef struct packed {
		logic            go;
		logic [SumW-1:0] dividend;
		logic [CntW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [SumW-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/gfa_divider.sv =====
// Shared signed-by-unsigned restoring divider, one quotient bit per cycle.
module gfa_divider import gfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int StepW = $clog2(SumW + 1);

	logic [SumW-1:0]  mag_q;
	logic [CntW-1:0]  rem_q;
	logic [CntW-1:0]  den_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [StepW-1:0] step_q;
	logic [CntW:0]    trial;
	logic [CntW-1:0]  diff;
	logic             fits;

	// remainder stays below the divisor, so eight bits hold it
	assign trial = {rem_q, mag_q[SumW-1]};
	assign diff  = trial[CntW-1:0] - den_q;
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				step_q <= StepW'(SumW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			neg_q <= req.dividend[SumW-1];
			mag_q <= req.dividend[SumW-1] ? (~req.dividend + 1'b1) : req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift in next dividend bit, quotient bit lands at the bottom
			rem_q <= fits ? diff : trial[CntW-1:0];
			mag_q <= {mag_q[SumW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (~mag_q + 1'b1) : mag_q;

	assert property (@(posedge clk) disable iff (!arst_n) !(done_q && busy_q))
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) !(req.go && busy_q))
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n) !(busy_q && den_q == '0))
		else $error("divide by zero");

endmodule

// ===== src/gnss_fix_averager.sv =====
// Top level of the GNSS fix averager: command decode, sums and finish sequencer.
//
// Channel   Direction  Handshake             Payload
// command   in         start && !busy        func lat lon alt qual_code hdop sat_used
// result    out        done (one cycle)      status ... worst_quality
// config    in         cfg_we                cfg_index cfg_data
//
// Begin, feed, abort and a refused finish pass from S_EXEC straight to S_OUT for the result.
// A successful finish runs five divisions, one per average, each through S_DIVGO and S_DIVW
// on the one shared divider, before S_OUT gives the result.
// busy is high from acceptance until the result cycle; start is ignored then.
// Reset clears the capture, the point count and the registers to defaults.
// The receiver cannot stall: each result shows for exactly one cycle.
module gnss_fix_averager import gfa_pkg::*; #(
	parameter int MAX_FIXES = MaxFixesDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [30:0] lat,
	input  logic signed [31:0] lon,
	input  logic signed [27:0] alt,
	input  logic [3:0]         qual_code,
	input  logic [13:0]        hdop,
	input  logic [7:0]         sat_used,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic [2:0]         status,
	output logic [7:0]         fix_count,
	output logic               ready_res,
	output logic [15:0]        point_no,
	output logic signed [30:0] avg_lat,
	output logic signed [31:0] avg_lon,
	output logic signed [27:0] avg_alt,
	output logic [13:0]        avg_hdop,
	output logic [7:0]         avg_sats,
	output logic [3:0]         worst_quality
);

	localparam logic [CntW-1:0] FixCap =
		(MAX_FIXES < 255) ? CntW'(MAX_FIXES) : CntW'(255);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_DIVGO = 5'b00100,
		S_DIVW = 5'b01000,
		S_OUT = 5'b10000
	} state_t;

	state_t state_q;

	logic [3:0]  min_q_q;
	logic [7:0]  req_q;
	logic [15:0] max_pts_q;

	logic            active_q, aborted_q;
	logic [CntW-1:0] fixes_q;
	logic [SumW-1:0] lat_tot_q, lon_tot_q;
	logic [35:0]     alt_tot_q;
	logic [21:0]     hdop_tot_q;
	logic [15:0]     sats_tot_q;
	logic [3:0]      lowq_q;
	logic [15:0]     pts_q;

	logic [1:0]  func_q;
	logic [30:0] lat_q;
	logic [31:0] lon_q;
	logic [27:0] alt_q;
	logic [3:0]  fq_q;
	logic [13:0] hdop_q;
	logic [7:0]  sats_q;

	logic [2:0]  sel_q;
	logic [2:0]  st_q;
	logic [15:0] pnum_q;
	logic [3:0]  fin_worst_q;
	logic        finished_q;
	logic [30:0] r_lat_q;
	logic [31:0] r_lon_q;
	logic [27:0] r_alt_q;
	logic [13:0] r_hdop_q;
	logic [7:0]  r_sats_q;

	div_req_t dreq;
	div_rsp_t drsp;

	gfa_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		dreq.go      = (state_q == S_DIVGO);
		dreq.divisor = fixes_q;
		case (sel_q)
			3'd0:    dreq.dividend = lat_tot_q;
			3'd1:    dreq.dividend = lon_tot_q;
			3'd2:    dreq.dividend = {{(SumW-36){alt_tot_q[35]}}, alt_tot_q};
			3'd3:    dreq.dividend = {{(SumW-22){1'b0}}, hdop_tot_q};
			default: dreq.dividend = {{(SumW-16){1'b0}}, sats_tot_q};
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q_q   <= 4'd1;
			req_q     <= 8'd10;
			max_pts_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_Q:   min_q_q   <= cfg_data[3:0];
				REG_REQ:     req_q     <= cfg_data[7:0];
				REG_MAX_PTS: max_pts_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q <= func;
			lat_q  <= lat;
			lon_q  <= lon;
			alt_q  <= alt;
			fq_q   <= qual_code;
			hdop_q <= hdop;
			sats_q <= sat_used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= 1'b0;
			aborted_q  <= 1'b0;
			fixes_q    <= '0;
			lat_tot_q  <= '0;
			lon_tot_q  <= '0;
			alt_tot_q  <= '0;
			hdop_tot_q <= '0;
			sats_tot_q <= '0;
			lowq_q     <= QUAL_SEED;
			pts_q      <= '0;
			sel_q      <= '0;
			st_q       <= ST_OK;
			pnum_q     <= '0;
			fin_worst_q <= '0;
			finished_q <= 1'b0;
			done       <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					st_q       <= ST_OK;
					pnum_q     <= '0;
					finished_q <= 1'b0;
					state_q    <= S_OUT;
					case (func_q)
						FUNC_BEGIN: begin
							if (active_q) st_q <= ST_WRONG;
							else begin
								active_q   <= 1'b1;
								aborted_q  <= 1'b0;
								fixes_q    <= '0;
								lat_tot_q  <= '0;
								lon_tot_q  <= '0;
								alt_tot_q  <= '0;
								hdop_tot_q <= '0;
								sats_tot_q <= '0;
								lowq_q     <= QUAL_SEED;
							end
						end
						FUNC_FEED: begin
							if (!active_q) st_q <= ST_WRONG;
							else if (aborted_q) st_q <= ST_ABORTED;
							else if (fq_q < min_q_q) begin
								aborted_q <= 1'b1;
								st_q      <= ST_ABORTED;
							end else if (fixes_q >= FixCap) st_q <= ST_FULL;
							else begin
								lat_tot_q  <= lat_tot_q + {{(SumW-31){lat_q[30]}}, lat_q};
								lon_tot_q  <= lon_tot_q + {{(SumW-32){lon_q[31]}}, lon_q};
								alt_tot_q  <= alt_tot_q + {{8{alt_q[27]}}, alt_q};
								hdop_tot_q <= hdop_tot_q + {8'd0, hdop_q};
								sats_tot_q <= sats_tot_q + {8'd0, sats_q};
								if (fq_q < lowq_q) lowq_q <= fq_q;
								fixes_q <= fixes_q + 1'b1;
							end
						end
						FUNC_FINISH: begin
							if (!active_q) st_q <= ST_WRONG;
							else if (aborted_q) begin
								st_q      <= ST_ABORTED;
								active_q  <= 1'b0;
								aborted_q <= 1'b0;
								fixes_q   <= '0;
								lowq_q    <= QUAL_SEED;
							end else if (fixes_q == '0 || fixes_q < req_q) st_q <= ST_TOO_FEW;
							else if (pts_q >= max_pts_q) st_q <= ST_PT_LIMIT;
							else begin
								sel_q   <= '0;
								state_q <= S_DIVGO;
							end
						end
						default: begin
							if (!active_q) st_q <= ST_WRONG;
							else begin
								active_q  <= 1'b0;
								aborted_q <= 1'b0;
								fixes_q   <= '0;
								lowq_q    <= QUAL_SEED;
							end
						end
					endcase
				end
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW: begin
					if (drsp.done) begin
						if (sel_q == 3'd4) begin
							// all five averages taken: number the point, clear
							pts_q       <= pts_q + 1'b1;
							pnum_q      <= pts_q + 1'b1;
							fin_worst_q <= lowq_q;
							finished_q  <= 1'b1;
							active_q    <= 1'b0;
							aborted_q   <= 1'b0;
							fixes_q     <= '0;
							lowq_q      <= QUAL_SEED;
							state_q     <= S_OUT;
						end else begin
							sel_q   <= sel_q + 1'b1;
							state_q <= S_DIVGO;
						end
					end
				end
				S_OUT: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			r_lat_q  <= '0;
			r_lon_q  <= '0;
			r_alt_q  <= '0;
			r_hdop_q <= '0;
			r_sats_q <= '0;
		end else if (state_q == S_DIVW && drsp.done) begin
			case (sel_q)
				3'd0:    r_lat_q  <= drsp.quotient[30:0];
				3'd1:    r_lon_q  <= drsp.quotient[31:0];
				3'd2:    r_alt_q  <= drsp.quotient[27:0];
				3'd3:    r_hdop_q <= drsp.quotient[13:0];
				default: r_sats_q <= drsp.quotient[7:0];
			endcase
		end
	end

	assign status        = st_q;
	assign fix_count     = active_q ? fixes_q : '0;
	assign ready_res     = active_q && !aborted_q && fixes_q != '0 && fixes_q >= req_q;
	assign point_no      = pnum_q;
	assign avg_lat       = r_lat_q;
	assign avg_lon       = r_lon_q;
	assign avg_alt       = r_alt_q;
	assign avg_hdop      = r_hdop_q;
	assign avg_sats      = r_sats_q;
	assign worst_quality = finished_q ? fin_worst_q : lowq_q;

	assert property (@(posedge clk) disable iff (!arst_n) !(done && busy))
		else $error("result while busy");
	assert property (@(posedge clk) disable iff (!arst_n) !(aborted_q && !active_q))
		else $error("aborted without capture");
	assert property (@(posedge clk) disable iff (!arst_n) fixes_q <= FixCap)
		else $error("fix count beyond cap");
	assert property (@(posedge clk) disable iff (!arst_n) !(state_q == S_DIVW && fixes_q == '0))
		else $error("divide by no fixes");

endmodule

// ===== tb/sv/gnss_fix_averager_tb.sv =====
// Testbench of the GNSS fix averager: directed table, then random captures against a predictor.
`timescale 1ns / 100ps

module gnss_fix_averager_tb import gfa_pkg::*; ();

	typedef struct {
		logic [1:0]         func;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic signed [27:0] alt;
		logic [3:0]         q;
		logic [13:0]        hdop;
		logic [7:0]         sats;
	} fix_cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         fix_count;
		logic               ready_res;
		logic [15:0]        point_no;
		logic signed [30:0] avg_lat;
		logic signed [31:0] avg_lon;
		logic signed [27:0] avg_alt;
		logic [13:0]        avg_hdop;
		logic [7:0]         avg_sats;
		logic [3:0]         worst;
	} point_res_t;

	typedef struct {
		fix_cmd_t   cmd;
		logic       typed;
		point_res_t res;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] func = '0;
	logic signed [30:0] lat = '0;
	logic signed [31:0] lon = '0;
	logic signed [27:0] alt = '0;
	logic [3:0] qual_code = '0;
	logic [13:0] hdop = '0;
	logic [7:0] sat_used = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic done;
	logic [2:0] status;
	logic [7:0] fix_count;
	logic ready_res;
	logic [15:0] point_no;
	logic signed [30:0] avg_lat;
	logic signed [31:0] avg_lon;
	logic signed [27:0] avg_alt;
	logic [13:0] avg_hdop;
	logic [7:0] avg_sats;
	logic [3:0] worst_quality;

	gnss_fix_averager i_dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [3:0]  p_minq;
	logic [7:0]  p_req;
	logic [15:0] p_maxpts;
	logic        p_active, p_aborted;
	int          p_count;
	longint      p_lat, p_lon, p_alt, p_hdop, p_sats;
	logic [3:0]  p_lowq;
	int          p_points;

	point_res_t expected_points[$];
	int errors = 0;
	int mismatches = 0;
	bit quiet = 0;

	function automatic void clear_sums();
		p_active = 0; p_aborted = 0; p_count = 0;
		p_lat = 0; p_lon = 0; p_alt = 0; p_hdop = 0; p_sats = 0;
		p_lowq = QUAL_SEED;
	endfunction

	function automatic point_res_t predict_point(fix_cmd_t c);
		point_res_t r;
		logic fin;
		logic [3:0] fq;
		longint n;
		r = '{default: '0};
		fin = 0;
		fq = '0;
		case (c.func)
			FUNC_BEGIN: begin
				if (p_active) r.status = ST_WRONG;
				else begin
					clear_sums();
					p_active = 1;
				end
			end
			FUNC_FEED: begin
				if (!p_active) r.status = ST_WRONG;
				else if (p_aborted) r.status = ST_ABORTED;
				else if (c.q < p_minq) begin
					p_aborted = 1;
					r.status = ST_ABORTED;
				end else if (p_count >= (MaxFixesDefault < 255 ? MaxFixesDefault : 255))
					r.status = ST_FULL;
				else begin
					p_lat += longint'(c.lat);
					p_lon += longint'(c.lon);
					p_alt += longint'(c.alt);
					p_hdop += longint'(c.hdop);
					p_sats += longint'(c.sats);
					if (c.q < p_lowq) p_lowq = c.q;
					p_count++;
				end
			end
			FUNC_FINISH: begin
				if (!p_active) r.status = ST_WRONG;
				else if (p_aborted) begin
					clear_sums();
					r.status = ST_ABORTED;
				end else if (p_count == 0 || p_count < p_req) r.status = ST_TOO_FEW;
				else if (p_points >= p_maxpts) r.status = ST_PT_LIMIT;
				else begin
					n = p_count;
					r.avg_lat = 31'(p_lat / n);
					r.avg_lon = 32'(p_lon / n);
					r.avg_alt = 28'(p_alt / n);
					r.avg_hdop = 14'(p_hdop / n);
					r.avg_sats = 8'(p_sats / n);
					p_points++;
					r.point_no = 16'(p_points);
					fq = p_lowq;
					fin = 1;
					clear_sums();
				end
			end
			default: begin
				if (!p_active) r.status = ST_WRONG;
				else clear_sums();
			end
		endcase
		r.worst = fin ? fq : p_lowq;
		r.fix_count = p_active ? 8'(p_count) : 8'd0;
		r.ready_res = p_active && !p_aborted && p_count >= 1 && p_count >= p_req;
		return r;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_MIN_Q: p_minq = val[3:0];
			REG_REQ: p_req = val[7:0];
			default: p_maxpts = val;
		endcase
	endtask

	// wait for quiet, then a margin for any result still on its way
	task automatic settle();
		while (expected_points.size() != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic send_cmd(fix_cmd_t c, logic typed, point_res_t want);
		point_res_t r;
		if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 13)) @(negedge clk);
		func = c.func; lat = c.lat; lon = c.lon; alt = c.alt;
		qual_code = c.q; hdop = c.hdop; sat_used = c.sats;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = predict_point(c);
		if (typed && r != want) begin
			errors++;
			$display("typed row disagrees with predictor: func %0d", c.func);
		end
		expected_points.push_back(typed ? want : r);
		@(negedge clk);
		start = 1'b0;
	endtask

	function automatic fix_cmd_t rand_fix(logic [1:0] f, int qlo);
		fix_cmd_t c;
		c.func = f;
		c.lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
		c.lon = 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
		c.alt = 28'($signed($urandom_range(0, 200000000)) - 100000000);
		c.q = 4'($urandom_range(qlo, 15));
		c.hdop = 14'($urandom_range(0, 16383));
		c.sats = 8'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			c.lat = 31'($urandom); c.lon = 32'($urandom); c.alt = 28'($urandom);
		end
		return c;
	endfunction

	always @(posedge clk) begin
		point_res_t w;
		if (done) begin
			if (expected_points.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result, status %0d", status);
			end else begin
				w = expected_points.pop_front();
				if (status !== w.status || fix_count !== w.fix_count ||
				    ready_res !== w.ready_res || point_no !== w.point_no ||
				    avg_lat !== w.avg_lat || avg_lon !== w.avg_lon ||
				    avg_alt !== w.avg_alt || avg_hdop !== w.avg_hdop ||
				    avg_sats !== w.avg_sats || worst_quality !== w.worst) begin
					errors++;
					if (mismatches++ < 10) begin
						$display("mismatch: exp st %0d cnt %0d rdy %0d pt %0d lat %0d lon %0d",
							w.status, w.fix_count, w.ready_res, w.point_no, w.avg_lat,
							w.avg_lon, " alt %0d hd %0d sa %0d wq %0d",
							w.avg_alt, w.avg_hdop, w.avg_sats, w.worst);
						$display("          got st %0d cnt %0d rdy %0d pt %0d lat %0d lon %0d",
							status, fix_count, ready_res, point_no, avg_lat,
							avg_lon, " alt %0d hd %0d sa %0d wq %0d",
							avg_alt, avg_hdop, avg_sats, worst_quality);
					end
				end
			end
		end
	end

	initial begin
		#60ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		table_row_t dir[$];
		table_row_t row;
		point_res_t z;
		fix_cmd_t c;
		int sent, n, next_cfg;
		p_minq = 4'd1; p_req = 8'd10; p_maxpts = 16'd1000; p_points = 0;
		clear_sums();
		z = '{default: '0};
		z.worst = QUAL_SEED;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		write_reg(REG_REQ, 16'd2);
		// wrong-state cases after reset, then a begin, a second begin and a too-early finish: typed
		row.typed = 1; row.res = z; row.res.status = ST_WRONG;
		row.cmd = '{FUNC_FEED, 31'sd900000000, 32'sd1800000000, 28'sd100000000,
			4'd8, 14'd9999, 8'd255};
		dir.push_back(row);
		row.cmd.func = FUNC_FINISH; dir.push_back(row);
		row.cmd.func = FUNC_ABORT; dir.push_back(row);
		row.cmd.func = FUNC_BEGIN; row.res = z; row.res.status = ST_OK; row.res.fix_count = 0;
		dir.push_back(row);
		row.res.status = ST_WRONG; dir.push_back(row);
		row.cmd.func = FUNC_FINISH; row.res.status = ST_TOO_FEW; dir.push_back(row);
		row.typed = 0;
		row.cmd = '{FUNC_FEED, 31'sd900000000, 32'sd1800000000, 28'sd100000000,
			4'd8, 14'd9999, 8'd255};
		dir.push_back(row);
		row.cmd = '{FUNC_FEED, -31'sd900000000, -32'sd1800000000, -28'sd100000000,
			4'd15, 14'd16383, 8'd0};
		dir.push_back(row);
		row.cmd = '{FUNC_FEED, -31'sd7, -32'sd3, -28'sd5, 4'd1, 14'd0, 8'd3};
		dir.push_back(row);
		row.cmd.func = FUNC_FINISH; dir.push_back(row);
		row.cmd.func = FUNC_BEGIN; dir.push_back(row);
		row.cmd = '{FUNC_FEED, 31'sd5, 32'sd5, 28'sd5, 4'd0, 14'd5, 8'd5}; dir.push_back(row);
		row.cmd.q = 4'd9; dir.push_back(row);
		row.cmd.func = FUNC_BEGIN; dir.push_back(row);
		row.cmd.func = FUNC_FINISH; dir.push_back(row);
		row.cmd.func = FUNC_BEGIN; dir.push_back(row);
		row.cmd.func = FUNC_ABORT; dir.push_back(row);
		foreach (dir[i]) send_cmd(dir[i].cmd, dir[i].typed, dir[i].res);
		settle();

		// count full: 255 fixes then one more
		write_reg(REG_MIN_Q, 16'd0);
		write_reg(REG_REQ, 16'd255);
		send_cmd(rand_fix(FUNC_BEGIN, 0), 0, z);
		quiet = 1;
		repeat (256) send_cmd(rand_fix(FUNC_FEED, 0), 0, z);
		quiet = 0;
		send_cmd(rand_fix(FUNC_FINISH, 0), 0, z);
		settle();

		// point limit
		write_reg(REG_MAX_PTS, 16'd1);
		write_reg(REG_REQ, 16'd1);
		send_cmd(rand_fix(FUNC_BEGIN, 0), 0, z);
		send_cmd(rand_fix(FUNC_FEED, 0), 0, z);
		send_cmd(rand_fix(FUNC_FINISH, 0), 0, z);
		send_cmd(rand_fix(FUNC_ABORT, 0), 0, z);
		settle();

		sent = 0;
		next_cfg = 0;
		while (sent < 770) begin
			if (sent >= next_cfg) begin
				settle();
				case ((next_cfg / 150) % 4)
					0: begin write_reg(REG_MIN_Q, 16'd8); write_reg(REG_REQ, 16'd1);
						write_reg(REG_MAX_PTS, 16'd65535); end
					1: begin write_reg(REG_MIN_Q, 16'($urandom_range(0, 15)));
						write_reg(REG_REQ, 16'($urandom_range(1, 6)));
						write_reg(REG_MAX_PTS, 16'($urandom)); end
					2: begin write_reg(REG_MIN_Q, 16'd0); write_reg(REG_REQ, 16'd3);
						write_reg(REG_MAX_PTS, 16'd1); end
					default: begin write_reg(REG_MIN_Q, 16'd2); write_reg(REG_REQ, 16'd4);
						write_reg(REG_MAX_PTS, 16'd65535); end
				endcase
				next_cfg += 150;
			end
			quiet = (sent > 650);
			if ($urandom_range(0, 4) != 0) begin
				// well-formed capture
				send_cmd(rand_fix(FUNC_BEGIN, 0), 0, z);
				n = $urandom_range(1, 8);
				repeat (n) send_cmd(rand_fix(FUNC_FEED, $urandom_range(0, 9) == 0 ? 0 : 2), 0, z);
				send_cmd(rand_fix($urandom_range(0, 9) == 0 ? FUNC_ABORT : FUNC_FINISH, 0), 0, z);
				sent += n + 2;
			end else begin
				c = rand_fix(2'($urandom), 0);
				send_cmd(c, 0, z);
				sent++;
			end
		end
		settle();
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
